FILE: rtl/tdcfc_pkg.sv
package tdcfc_pkg;

    localparam int CHANNELS_DEF = 196;
    localparam int CHANNELS_PER_TDC_DEF = 49;
    localparam int BINS_DEF = 500;
    localparam int FIRST_BIN_DEF = 32;

    localparam int CORR_W = 17;
    localparam int CNT_W = 32;
    localparam int CH_W = 8;
    localparam int FT_W = 13;
    localparam int BIN_W = 9;
    localparam logic [CORR_W-1:0] FULL_SCALE_Q4 = 17'd80000;

    typedef enum logic [1:0] {
        KIND_HIT      = 2'd0,
        KIND_FINALIZE = 2'd1,
        KIND_LOOKUP   = 2'd2,
        KIND_NONE     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOT_FIN  = 2'd2,
        ST_BAD_CH   = 2'd3
    } status_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic clr;        // write zero at the sweep address
        logic load_item;  // capture the accepted item
        logic hit_wr;     // write back incremented count
        logic fin_start;  // begin a channel row
        logic fin_rd;     // issue a row read
        logic fin_acc;    // accumulate the returned word
        logic fin_end;    // store channel total
        logic lk_rd;      // issue the lookup read
        logic lk_div;     // start the divider
        logic lk_out;     // load the result register
    } cmd_t;

    typedef struct packed {
        logic       row_last;
        logic       ch_last;
        logic       clr_last;
        logic       div_done;
    } sts_t;

endpackage

FILE: rtl/tdc_fine_time_calibration.sv
// TDC code-density calibration.
// Input items arrive on s_axis: tuser carries the kind, tdata the channel, fine
// time and lookup bin. A hit adds one count to the channel histogram with a
// read-modify-write of the bin memory through its registered read, unless the
// channel is a reference channel, out of range, or the histogram is finalized. The
// first finalize sweeps every channel row, turning bins into running sums and
// storing each channel total; later finalize items are ignored. A lookup
// returns one result item on m_axis, through the bit-serial divider of 49 steps
// when the bin needs the divide; s_tready returns in the cycle the result
// appears. After reset a clearing pass writes zero to the whole bin memory and
// the channel totals, while s_tready stays low.
// One item is worked at a time. A stalled receiver holds the result in the
// output register; hits and finalize items go on meanwhile, and the next
// lookup holds in its read state until the register is free.
module tdc_fine_time_calibration #(
    parameter int CHANNELS = tdcfc_pkg::CHANNELS_DEF,
    parameter int CHANNELS_PER_TDC = tdcfc_pkg::CHANNELS_PER_TDC_DEF,
    parameter int BINS = tdcfc_pkg::BINS_DEF,
    parameter int FIRST_BIN = tdcfc_pkg::FIRST_BIN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // channel[7:0], fine_time[20:8], bin[29:21]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // correction[16:0], status[18:17]
);
    import tdcfc_pkg::*;

    cmd_t        cmd;
    sts_t        sts;
    logic        fin_flag;
    logic [16:0] corr;
    logic [1:0]  st;

    tdcfc_ctrl u_ctrl (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_kind(s_tuser),
        .in_ready(s_tready), .out_valid(m_tvalid), .out_ready(m_tready),
        .fin_flag, .cmd, .sts
    );

    tdcfc_datapath #(
        .CHANNELS(CHANNELS), .CHANNELS_PER_TDC(CHANNELS_PER_TDC),
        .BINS(BINS), .FIRST_BIN(FIRST_BIN)
    ) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .in_kind(s_tuser), .in_channel(s_tdata[7:0]),
        .in_fine_time(s_tdata[20:8]), .in_bin(s_tdata[29:21]),
        .fin_flag, .out_correction(corr), .out_status(st)
    );

    assign m_tdata = {5'd0, st, corr};

endmodule

FILE: rtl/tdcfc_ram.sv
module tdcfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/tdcfc_div.sv
// Restoring divider: one quotient bit per cycle.
module tdcfc_div #(
    parameter int NW = 49,
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;

    assign trial = {r_reg[DW-1:0], q_reg[NW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                q_reg    <= num;
                r_reg    <= '0;
                d_reg    <= den;
                cnt_reg  <= CW'(NW);
            end else if (busy_reg) begin
                if (trial >= {1'b0, d_reg}) begin
                    r_reg <= trial - {1'b0, d_reg};
                    q_reg <= {q_reg[NW-2:0], 1'b1};
                end else begin
                    r_reg <= trial;
                    q_reg <= {q_reg[NW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

FILE: rtl/tdcfc_datapath.sv
module tdcfc_datapath #(
    parameter int CHANNELS = 196,
    parameter int CHANNELS_PER_TDC = 49,
    parameter int BINS = 500,
    parameter int FIRST_BIN = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  tdcfc_pkg::cmd_t         cmd,
    output tdcfc_pkg::sts_t         sts,
    input  logic [1:0]              in_kind,
    input  logic [7:0]              in_channel,
    input  logic [12:0]             in_fine_time,
    input  logic [8:0]              in_bin,
    input  logic                    fin_flag,
    output logic [16:0]             out_correction,
    output logic [1:0]              out_status
);
    import tdcfc_pkg::*;

    localparam int ROW = BINS + 2;
    localparam int DEPTH = CHANNELS * ROW;
    localparam int AW = $clog2(DEPTH);
    localparam int RW = $clog2(ROW);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NW = CNT_W + CORR_W;
    localparam logic [CNT_W:0] SAT = {1'b0, {CNT_W{1'b1}}};

    logic [CH_W-1:0]  ch_reg;
    logic [BIN_W-1:0] bin_reg;
    logic [RW-1:0]    hb_reg;
    logic             skip_reg;
    logic [AW-1:0]    base_reg;
    logic [AW-1:0]    clr_addr_reg;
    logic [CW-1:0]    fch_reg;
    logic [RW-1:0]    rb_reg;
    logic [RW-1:0]    wb_reg;
    logic [CNT_W-1:0] tot_reg;
    logic [CNT_W-1:0] cum_reg;
    logic [16:0]      corr_reg;
    logic [1:0]       st_reg;
    logic [1:0]       lk_st_reg;
    logic [16:0]      lk_fix_reg;
    logic             lk_divide_reg;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [CNT_W-1:0] wdata, rdata;
    logic [CNT_W-1:0] tot_we_data, tot_rdata;
    logic             tot_we;
    logic [CW-1:0]    tot_addr;
    logic [CNT_W-1:0] tot_sum, cum_sum, inc;
    logic [NW-1:0]    quo;
    logic [NW-1:0]    lk_num;
    logic             div_done;
    logic [BIN_W-1:0] bin_c;
    logic             ref_ch;
    logic [RW-1:0]    ft_bin;
    logic [25:0]      ft_prod;

    tdcfc_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_bins (
        .aclk, .we, .waddr, .wdata, .raddr, .rdata
    );
    tdcfc_ram #(.WIDTH(CNT_W), .DEPTH(CHANNELS)) u_tot (
        .aclk, .we(tot_we), .waddr(tot_addr), .wdata(tot_we_data),
        .raddr(tot_addr), .rdata(tot_rdata)
    );

    function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? SAT[CNT_W-1:0] : s[CNT_W-1:0];
    endfunction

    // Reference channels are the multiples of CHANNELS_PER_TDC, matched
    // against a constant list of every multiple that fits the channel field.
    function automatic logic is_ref(logic [CH_W-1:0] ch);
        logic r;
        r = 1'b0;
        for (int k = 0; k < 256; k++) begin
            if ((k * CHANNELS_PER_TDC < 256) && (ch == CH_W'(k * CHANNELS_PER_TDC))) begin
                r = 1'b1;
            end
        end
        return r;
    endfunction

    // Bin index from fine time; the divide by ten is a multiply by 6554/65536,
    // which is exact for every 13-bit time.
    assign ft_prod = 26'(in_fine_time) * 26'd6554;
    assign ft_bin = (32'(in_fine_time) >= 32'(BINS * 10)) ? RW'(BINS + 1)
                  : RW'(ft_prod[25:16]) + RW'(1);
    assign ref_ch = is_ref(in_channel);
    assign inc = sat_add(rdata, 32'd1);
    assign tot_sum = sat_add(tot_reg, rdata);
    assign cum_sum = sat_add(cum_reg, rdata);
    assign bin_c = (32'(bin_reg) >= 32'(BINS)) ? BIN_W'(BINS - 1) : bin_reg;

    always_comb begin
        we = 1'b0;
        waddr = AW'(base_reg + AW'(hb_reg));
        wdata = inc;
        raddr = AW'(base_reg + AW'(hb_reg));
        if (cmd.clr) begin
            we = 1'b1;
            waddr = clr_addr_reg;
            wdata = '0;
        end else if (cmd.hit_wr) begin
            we = !skip_reg;
        end else if (cmd.fin_rd || cmd.fin_acc) begin
            raddr = AW'(base_reg + AW'(rb_reg));
            waddr = AW'(base_reg + AW'(wb_reg));
            wdata = cum_sum;
            we = cmd.fin_acc && (32'(wb_reg) >= FIRST_BIN) && (32'(wb_reg) < BINS);
        end else if (cmd.lk_rd) begin
            raddr = AW'(base_reg + AW'(bin_c));
        end
    end

    assign tot_we = cmd.clr ? (32'(clr_addr_reg) < CHANNELS) : cmd.fin_end;
    assign tot_addr = cmd.clr ? CW'(clr_addr_reg) : (cmd.fin_end || cmd.fin_start
                    || cmd.fin_rd || cmd.fin_acc) ? fch_reg : CW'(ch_reg);
    assign tot_we_data = cmd.clr ? '0 : tot_reg;

    // The running sum and the total come straight from the memories in the
    // cycle after the lookup read.
    assign lk_num = NW'(rdata) * NW'(FULL_SCALE_Q4) + NW'(tot_rdata >> 1);

    tdcfc_div #(.NW(NW), .DW(CNT_W)) u_div (
        .aclk, .aresetn, .start(cmd.lk_div),
        .num(lk_num),
        .den(tot_rdata), .done(div_done), .quo
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            fch_reg <= '0;
        end else begin
            if (cmd.clr) clr_addr_reg <= clr_addr_reg + 1'b1;
            if (cmd.load_item) begin
                ch_reg   <= in_channel;
                bin_reg  <= in_bin;
                hb_reg   <= ft_bin;
                skip_reg <= fin_flag || (32'(in_channel) >= CHANNELS) || ref_ch;
                base_reg <= AW'(32'(in_channel) * ROW);
                lk_divide_reg <= 1'b0;
                if (in_kind == KIND_FINALIZE) begin
                    fch_reg <= '0;
                    base_reg <= '0;
                end
                if (32'(in_channel) >= CHANNELS) begin
                    lk_st_reg <= ST_BAD_CH; lk_fix_reg <= '0;
                end else if (!fin_flag) begin
                    lk_st_reg <= ST_NOT_FIN; lk_fix_reg <= '0;
                end else if (ref_ch) begin
                    lk_st_reg <= ST_OK;
                    lk_fix_reg <= 17'((32'(in_bin) >= BINS ? BINS - 1 : 32'(in_bin)) * 160);
                end else begin
                    lk_st_reg <= ST_OK; lk_fix_reg <= '0;
                    lk_divide_reg <= (32'(in_bin) >= FIRST_BIN);
                end
            end
            if (cmd.fin_start) begin
                rb_reg <= '0; wb_reg <= '0; tot_reg <= '0; cum_reg <= '0;
            end
            if (cmd.fin_rd) rb_reg <= rb_reg + 1'b1;
            if (cmd.fin_acc) begin
                wb_reg <= wb_reg + 1'b1;
                tot_reg <= tot_sum;
                if ((32'(wb_reg) >= FIRST_BIN) && (32'(wb_reg) < BINS)) cum_reg <= cum_sum;
            end
            if (cmd.fin_end) begin
                fch_reg  <= fch_reg + 1'b1;
                base_reg <= AW'(base_reg + AW'(ROW));
            end
            if (cmd.lk_out) begin
                if (lk_st_reg != ST_OK) begin
                    corr_reg <= '0; st_reg <= lk_st_reg;
                end else if (lk_divide_reg && tot_rdata == '0) begin
                    corr_reg <= '0; st_reg <= ST_EMPTY;
                end else if (is_ref(ch_reg)) begin
                    corr_reg <= lk_fix_reg; st_reg <= ST_OK;
                end else if (tot_rdata == '0) begin
                    corr_reg <= '0; st_reg <= ST_EMPTY;
                end else if (lk_divide_reg) begin
                    corr_reg <= (quo > NW'(FULL_SCALE_Q4)) ? FULL_SCALE_Q4 : quo[16:0];
                    st_reg <= ST_OK;
                end else begin
                    corr_reg <= '0; st_reg <= ST_OK;
                end
            end
        end
    end

    assign sts.row_last = (32'(rb_reg) == ROW - 1);
    assign sts.ch_last  = (32'(fch_reg) == CHANNELS - 1);
    assign sts.clr_last = (32'(clr_addr_reg) == DEPTH - 1);
    assign sts.div_done = div_done || !lk_divide_reg || (lk_st_reg != ST_OK)
                        || (tot_rdata == '0);
    assign out_correction = corr_reg;
    assign out_status = st_reg;

endmodule

FILE: rtl/tdcfc_ctrl.sv
module tdcfc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic [1:0]      in_kind,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            fin_flag,
    output tdcfc_pkg::cmd_t cmd,
    input  tdcfc_pkg::sts_t sts
);
    import tdcfc_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HIT_RD, S_HIT_WR, S_FIN_ST, S_FIN_RD,
        S_FIN_LAST, S_FIN_END, S_LK_RD, S_LK_DIV, S_LK_WAIT, S_OUT
    } state_t;

    state_t state_reg;
    logic   fin_reg;
    logic   ov_reg;
    logic   wait_gap_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign fin_flag  = fin_reg;

    always_comb begin
        cmd = '0;
        cmd.load_item = in_valid && in_ready;
        unique case (state_reg)
            S_CLEAR:    cmd.clr = 1'b1;
            S_IDLE:     ;
            S_HIT_RD:   ;
            S_HIT_WR:   cmd.hit_wr = 1'b1;
            S_FIN_ST:   cmd.fin_start = 1'b1;
            S_FIN_RD:   begin cmd.fin_rd = 1'b1; cmd.fin_acc = wait_gap_reg; end
            S_FIN_LAST: cmd.fin_acc = 1'b1;
            S_FIN_END:  cmd.fin_end = 1'b1;
            S_LK_RD:    cmd.lk_rd = 1'b1;
            S_LK_DIV:   cmd.lk_div = 1'b1;
            S_LK_WAIT:  cmd.lk_out = sts.div_done && !wait_gap_reg;
            S_OUT:      ;
            default:    ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            fin_reg <= 1'b0;
            ov_reg <= 1'b0;
            wait_gap_reg <= 1'b0;
        end else begin
            if (ov_reg && out_ready) ov_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR: if (sts.clr_last) state_reg <= S_IDLE;
                S_IDLE: begin
                    if (in_valid && in_ready) begin
                        unique case (kind_t'(in_kind))
                            KIND_HIT:      state_reg <= S_HIT_RD;
                            KIND_FINALIZE: if (!fin_reg) state_reg <= S_FIN_ST;
                            KIND_LOOKUP:   state_reg <= S_LK_RD;
                            default:       ;
                        endcase
                    end
                end
                S_HIT_RD: state_reg <= S_HIT_WR;
                S_HIT_WR: state_reg <= S_IDLE;
                S_FIN_ST: begin state_reg <= S_FIN_RD; wait_gap_reg <= 1'b0; end
                S_FIN_RD: begin
                    wait_gap_reg <= 1'b1;
                    if (sts.row_last) state_reg <= S_FIN_LAST;
                end
                S_FIN_LAST: state_reg <= S_FIN_END;
                S_FIN_END: begin
                    if (sts.ch_last) begin
                        state_reg <= S_IDLE;
                        fin_reg <= 1'b1;
                    end else begin
                        state_reg <= S_FIN_ST;
                    end
                end
                // A lookup holds here until the previous result has been taken,
                // so the result register is never overwritten.
                S_LK_RD: if (!ov_reg) state_reg <= S_LK_DIV;
                S_LK_DIV: begin state_reg <= S_LK_WAIT; wait_gap_reg <= 1'b1; end
                S_LK_WAIT: begin
                    wait_gap_reg <= 1'b0;
                    if (sts.div_done && !wait_gap_reg) state_reg <= S_OUT;
                end
                S_OUT: begin
                    ov_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !in_ready) else $error("accept while busy");
    a_fin_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(fin_reg) |-> fin_reg) else $error("finalized flag dropped");
    a_out_after_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ov_reg) |-> $past(state_reg == S_OUT)) else $error("spurious result");
`endif

endmodule
